// ===== sv/bba_pkg.sv =====
`timescale 1ns / 1ps

package bba_pkg;

    localparam int CODE_W   = 64;
    localparam int PRICE_W  = 32;
    localparam int QTY_W    = 31;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 6;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UPDATED   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNCHANGED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    typedef struct packed {
        logic [PRICE_W-1:0] bid;
        logic [QTY_W-1:0]   bid_qty;
        logic [PRICE_W-1:0] ask;
        logic [QTY_W-1:0]   ask_qty;
    } t_entry;

    // fold a..z to upper case, every other byte kept as is
    function automatic logic [CODE_W-1:0] fold_symbol(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] key;
        logic [7:0]        ch;
        key = '0;
        for (int b = 0; b < CODE_W / 8; b++) begin
            ch = code[8*b +: 8];
            if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
                ch = ch - CASE_OFFSET;
            end
            key[8*b +: 8] = ch;
        end
        return key;
    endfunction

endpackage

// ===== sv/bba_key_store.sv =====
`timescale 1ns / 1ps

module bba_key_store #(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6,
    parameter int KEY_W = 64
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  logic [KEY_W-1:0] i_wr_key,
    input  logic [IDX_W-1:0] i_rd_addr,
    input  logic [KEY_W-1:0] i_cmp_key,
    output logic             o_match
);

    logic [KEY_W-1:0] r_mem [DEPTH];
    logic [KEY_W-1:0] r_rd_key;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_key;
        end
        r_rd_key <= r_mem[i_rd_addr];
    end

    // shared compare unit: stored key of last cycle's address against the quote key
    assign o_match = (r_rd_key == i_cmp_key);

endmodule

// ===== sv/bba_entry_store.sv =====
`timescale 1ns / 1ps

module bba_entry_store #(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  bba_pkg::t_entry  i_wr_entry,
    input  logic [IDX_W-1:0] i_rd_addr,
    output bba_pkg::t_entry  o_rd_entry
);

    import bba_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd_entry;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_entry;
        end
        r_rd_entry <= r_mem[i_rd_addr];
    end

    assign o_rd_entry = r_rd_entry;

endmodule

// ===== sv/per_symbol_best_bid_ask_table.sv =====
`timescale 1ns / 1ps

// Top-of-book table: each quote beat carries a symbol of up to 8 ASCII bytes
// (first character in the top byte), bid and ask prices in 1/10000 units and
// their sizes. Lower-case letters are folded to upper case and the top
// SYMBOL_BYTES bytes form the key. Entries fill in order from slot 0; a new
// symbol is stored with its quote as it is (status inserted), a known one
// takes a strictly higher bid and/or a strictly lower ask together with its
// size (status updated, else unchanged), and a new symbol with no free slot
// is dropped (status full, all other result fields zero). One result beat
// per quote, always. Search: with the output register free, a quote that finds
// its symbol in slot k compares slots 0 to k and a new symbol compares every
// filled entry before the next accept; the search is paced by the single
// key memory read port and its comparator, which walk the filled entries one
// per cycle behind a registered read, followed by one read-modify-write on
// the entry memory. A result waits in the output register while the next
// quote is already being accepted and searched; a result that cannot leave
// holds the sequencer in its write cycle.
module per_symbol_best_bid_ask_table #(
    parameter int TABLE_ENTRIES = 64,
    parameter int SYMBOL_BYTES  = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // quote channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [bba_pkg::CODE_W-1:0]    i_symbol_code,
    input  logic [bba_pkg::PRICE_W-1:0]   i_bid_price,
    input  logic [bba_pkg::PRICE_W-1:0]   i_ask_price,
    input  logic [bba_pkg::QTY_W-1:0]     i_bid_size,
    input  logic [bba_pkg::QTY_W-1:0]     i_ask_size,
    // result channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [bba_pkg::STATUS_W-1:0]  o_status,
    output logic [bba_pkg::SLOT_W-1:0]    o_slot,
    output logic [bba_pkg::PRICE_W-1:0]   o_best_bid,
    output logic [bba_pkg::QTY_W-1:0]     o_best_bid_qty,
    output logic [bba_pkg::PRICE_W-1:0]   o_best_ask,
    output logic [bba_pkg::QTY_W-1:0]     o_best_ask_qty
);

    import bba_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int KEY_W = 8 * SYMBOL_BYTES;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;
    localparam logic [1:0] S_INS  = 2'd3;

    logic [1:0]         r_state;
    logic [1:0]         n_state;

    // quote held for the whole search
    logic [KEY_W-1:0]   r_key;
    logic [PRICE_W-1:0] r_bid;
    logic [PRICE_W-1:0] r_ask;
    logic [QTY_W-1:0]   r_bid_qty;
    logic [QTY_W-1:0]   r_ask_qty;

    // scan pointers: r_idx is the address issued, r_chk_idx the one being compared
    logic [CNT_W-1:0]   r_idx;
    logic [CNT_W-1:0]   r_chk_idx;
    logic               r_chk_vld;
    logic [CNT_W-1:0]   r_used;

    // result register
    logic               r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [SLOT_W-1:0]  r_out_slot;
    t_entry             r_out_entry;

    logic [CODE_W-1:0]  folded;
    logic               in_acc;
    logic               out_free;
    logic               issue;
    logic               key_match;
    logic               hit_now;
    logic               scan_miss;
    logic               ins_ok;
    logic               bid_up;
    logic               ask_dn;
    logic               finish;

    t_entry             rd_entry;
    t_entry             upd_entry;
    t_entry             quote_entry;
    t_entry             ent_wr_data;
    logic               ent_wr_en;
    logic [IDX_W-1:0]   ent_wr_addr;
    logic               key_wr_en;

    logic [IDX_W-1:0]        slot_idx;
    logic [IDX_W+SLOT_W-1:0] slot_ext;

    assign o_ready  = (r_state == S_IDLE);
    assign in_acc   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;
    assign folded   = fold_symbol(i_symbol_code);

    assign issue     = (r_idx < r_used);
    assign hit_now   = r_chk_vld && key_match;
    // every filled entry compared and nothing in flight
    assign scan_miss = !r_chk_vld && !issue;
    assign ins_ok    = (r_used < CNT_W'(TABLE_ENTRIES));

    // best price update on the entry read back at the hit slot
    assign bid_up = (r_bid > rd_entry.bid);
    assign ask_dn = (r_ask < rd_entry.ask);

    always_comb begin
        upd_entry = rd_entry;
        if (bid_up) begin
            upd_entry.bid     = r_bid;
            upd_entry.bid_qty = r_bid_qty;
        end
        if (ask_dn) begin
            upd_entry.ask     = r_ask;
            upd_entry.ask_qty = r_ask_qty;
        end
    end

    assign quote_entry = '{bid: r_bid, bid_qty: r_bid_qty, ask: r_ask, ask_qty: r_ask_qty};

    assign finish = ((r_state == S_UPD) || (r_state == S_INS)) && out_free;

    always_comb begin
        ent_wr_en   = 1'b0;
        key_wr_en   = 1'b0;
        ent_wr_addr = r_chk_idx[IDX_W-1:0];
        ent_wr_data = upd_entry;
        if (r_state == S_UPD) begin
            ent_wr_en = out_free && (bid_up || ask_dn);
        end else if (r_state == S_INS) begin
            ent_wr_en   = out_free && ins_ok;
            key_wr_en   = out_free && ins_ok;
            ent_wr_addr = r_used[IDX_W-1:0];
            ent_wr_data = quote_entry;
        end
    end

    assign slot_idx = (r_state == S_INS) ? r_used[IDX_W-1:0] : r_chk_idx[IDX_W-1:0];
    assign slot_ext = {{SLOT_W{1'b0}}, slot_idx};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                priority if (hit_now) begin
                    n_state = S_UPD;
                end else if (scan_miss) begin
                    n_state = S_INS;
                end
            end
            S_UPD, S_INS: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_chk_idx   <= '0;
            r_chk_vld   <= 1'b0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_idx     <= '0;
                r_chk_vld <= 1'b0;
            end else if (r_state == S_SCAN && !hit_now) begin
                r_chk_vld <= issue;
                r_chk_idx <= r_idx;
                if (issue) begin
                    r_idx <= r_idx + CNT_W'(1);
                end
            end
            if (key_wr_en) begin
                r_used <= r_used + CNT_W'(1);
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // quote and result payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_key     <= folded[CODE_W-1 -: KEY_W];
            r_bid     <= i_bid_price;
            r_ask     <= i_ask_price;
            r_bid_qty <= i_bid_size;
            r_ask_qty <= i_ask_size;
        end
        if (finish) begin
            priority if (r_state == S_UPD) begin
                r_out_status <= (bid_up || ask_dn) ? ST_UPDATED : ST_UNCHANGED;
                r_out_slot   <= slot_ext[SLOT_W-1:0];
                r_out_entry  <= upd_entry;
            end else if (ins_ok) begin
                r_out_status <= ST_INSERTED;
                r_out_slot   <= slot_ext[SLOT_W-1:0];
                r_out_entry  <= quote_entry;
            end else begin
                r_out_status <= ST_FULL;
                r_out_slot   <= '0;
                r_out_entry  <= '0;
            end
        end
    end

    bba_key_store #(
        .DEPTH (TABLE_ENTRIES),
        .IDX_W (IDX_W),
        .KEY_W (KEY_W)
    ) u_key_store (
        .i_clk     (i_clk),
        .i_wr_en   (key_wr_en),
        .i_wr_addr (r_used[IDX_W-1:0]),
        .i_wr_key  (r_key),
        .i_rd_addr (r_idx[IDX_W-1:0]),
        .i_cmp_key (r_key),
        .o_match   (key_match)
    );

    // read address follows the compare pointer, so a hit's entry is ready in S_UPD
    bba_entry_store #(
        .DEPTH (TABLE_ENTRIES),
        .IDX_W (IDX_W)
    ) u_entry_store (
        .i_clk      (i_clk),
        .i_wr_en    (ent_wr_en),
        .i_wr_addr  (ent_wr_addr),
        .i_wr_entry (ent_wr_data),
        .i_rd_addr  (r_chk_idx[IDX_W-1:0]),
        .o_rd_entry (rd_entry)
    );

    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_slot         = r_out_slot;
    assign o_best_bid     = r_out_entry.bid;
    assign o_best_bid_qty = r_out_entry.bid_qty;
    assign o_best_ask     = r_out_entry.ask;
    assign o_best_ask_qty = r_out_entry.ask_qty;

    // fill count never passes the table size
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(TABLE_ENTRIES))
        else $error("fill count beyond table size");

    // a dropped quote reports an empty result
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |->
        (o_slot == '0 && o_best_bid == '0 && o_best_ask == '0 &&
         o_best_bid_qty == '0 && o_best_ask_qty == '0))
        else $error("dropped quote with nonzero result fields");

    // the fill count moves only with an inserted result
    a_used_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_used != $past(r_used)) |->
        (r_used == $past(r_used) + CNT_W'(1) && o_valid && o_status == ST_INSERTED))
        else $error("fill count changed without an insert");

    // one quote at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second quote accepted during search");

endmodule

// ===== verif/tb_per_symbol_best_bid_ask_table.sv =====
`timescale 1ns / 1ps

module tb_per_symbol_best_bid_ask_table;

    import bba_pkg::*;

    localparam int NUM_SLOTS     = 64;
    localparam int KEY_BYTES     = 8;
    localparam int POOL_SIZE     = 80;
    localparam int RANDOM_QUOTES = 1750;
    localparam int STALL_AT      = 350;     // quote count that starts the long sink stall
    localparam int STALL_CYCLES  = 600;
    localparam int PAUSE_AT      = 1200;    // random quote index where the source drains
    localparam int QUIET_FIRST   = 700;     // no idling on either side in this window
    localparam int QUIET_LAST    = 1000;
    localparam int TAIL_CYCLES   = 2 * (NUM_SLOTS + 4);
    localparam int CYCLE_LIMIT   = 1_000_000;

    localparam logic [CODE_W-1:0] KEY_MASK = {CODE_W{1'b1}} << (8 * (CODE_W / 8 - KEY_BYTES));
    localparam logic [7:0] UPPER_A = 8'h41;
    localparam logic [7:0] UPPER_Z = 8'h5a;

    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic [PRICE_W-1:0] bid;
        logic [PRICE_W-1:0] ask;
        logic [QTY_W-1:0]   bid_qty;
        logic [QTY_W-1:0]   ask_qty;
    } t_quote;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [PRICE_W-1:0]  bid;
        logic [QTY_W-1:0]    bid_qty;
        logic [PRICE_W-1:0]  ask;
        logic [QTY_W-1:0]    ask_qty;
    } t_book;

    typedef struct packed {
        t_quote q;
        bit     typed;
        t_book  want;
    } t_quote_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [CODE_W-1:0]   i_symbol_code;
    logic [PRICE_W-1:0]  i_bid_price;
    logic [PRICE_W-1:0]  i_ask_price;
    logic [QTY_W-1:0]    i_bid_size;
    logic [QTY_W-1:0]    i_ask_size;
    logic                o_valid;
    logic                i_ready;
    logic [STATUS_W-1:0] o_status;
    logic [SLOT_W-1:0]   o_slot;
    logic [PRICE_W-1:0]  o_best_bid;
    logic [QTY_W-1:0]    o_best_bid_qty;
    logic [PRICE_W-1:0]  o_best_ask;
    logic [QTY_W-1:0]    o_best_ask_qty;

    // typed-in expectation that rides along with the quote beat on offer
    bit                  typed_pending;
    t_book               typed_book;

    // predicted book
    bit                  book_valid [NUM_SLOTS];
    logic [CODE_W-1:0]   book_key [NUM_SLOTS];
    logic [PRICE_W-1:0]  book_bid [NUM_SLOTS];
    logic [QTY_W-1:0]    book_bid_qty [NUM_SLOTS];
    logic [PRICE_W-1:0]  book_ask [NUM_SLOTS];
    logic [QTY_W-1:0]    book_ask_qty [NUM_SLOTS];
    int                  books_used;

    t_book               expected_books [$];
    logic [CODE_W-1:0]   symbol_pool [POOL_SIZE];
    t_quote_row          directed_rows [$];
    int                  quotes_taken;
    int                  results_seen;
    int                  mismatch_count;
    int                  cycle_count;
    bit                  stall_done;

    per_symbol_best_bid_ask_table #(
        .TABLE_ENTRIES (NUM_SLOTS),
        .SYMBOL_BYTES  (KEY_BYTES)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_symbol_code  (i_symbol_code),
        .i_bid_price    (i_bid_price),
        .i_ask_price    (i_ask_price),
        .i_bid_size     (i_bid_size),
        .i_ask_size     (i_ask_size),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_slot         (o_slot),
        .o_best_bid     (o_best_bid),
        .o_best_bid_qty (o_best_bid_qty),
        .o_best_ask     (o_best_ask),
        .o_best_ask_qty (o_best_ask_qty)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // lower-case letters lose bit 5, everything else passes through; only the top KEY_BYTES bytes are kept
    function automatic logic [CODE_W-1:0] fold_key(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] key;
        logic [7:0]        ch;
        key = '0;
        for (int b = 0; b < CODE_W / 8; b++) begin
            ch = code[8*b +: 8];
            if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
                ch[5] = 1'b0;
            end
            key[8*b +: 8] = ch;
        end
        return key & KEY_MASK;
    endfunction

    function automatic bit find_entry(input logic [CODE_W-1:0] key, output int idx);
        idx = 0;
        for (int i = 0; i < books_used; i++) begin
            if (book_valid[i] && book_key[i] == key) begin
                idx = i;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // apply one quote to the predicted book and return the result beat it causes
    function automatic t_book book_update(input t_quote q);
        logic [CODE_W-1:0] key;
        int                idx;
        bit                changed;
        t_book             r;
        key = fold_key(q.code);
        r   = '0;
        if (find_entry(key, idx)) begin
            changed = 1'b0;
            if (q.bid > book_bid[idx]) begin
                book_bid[idx]     = q.bid;
                book_bid_qty[idx] = q.bid_qty;
                changed           = 1'b1;
            end
            if (q.ask < book_ask[idx]) begin
                book_ask[idx]     = q.ask;
                book_ask_qty[idx] = q.ask_qty;
                changed           = 1'b1;
            end
            r.status = changed ? ST_UPDATED : ST_UNCHANGED;
        end else if (books_used < NUM_SLOTS) begin
            idx               = books_used;
            book_valid[idx]   = 1'b1;
            book_key[idx]     = key;
            book_bid[idx]     = q.bid;
            book_bid_qty[idx] = q.bid_qty;
            book_ask[idx]     = q.ask;
            book_ask_qty[idx] = q.ask_qty;
            books_used++;
            r.status = ST_INSERTED;
        end else begin
            // dropped: every field but the status stays zero
            r.status = ST_FULL;
            return r;
        end
        r.slot    = idx[SLOT_W-1:0];
        r.bid     = book_bid[idx];
        r.bid_qty = book_bid_qty[idx];
        r.ask     = book_ask[idx];
        r.ask_qty = book_ask_qty[idx];
        return r;
    endfunction

    function automatic bit quiet_window();
        return quotes_taken >= QUIET_FIRST && quotes_taken < QUIET_LAST;
    endfunction

    function automatic logic [CODE_W-1:0] make_symbol();
        logic [CODE_W-1:0] code;
        logic [7:0]        ch;
        int                len;
        code = '0;
        len  = $urandom_range(1, KEY_BYTES);
        for (int b = 0; b < len; b++) begin
            case ($urandom_range(0, 9))
                7:       ch = 8'h30 + 8'($urandom_range(0, 9));
                8:       ch = 8'($urandom_range(1, 255));
                9:       ch = 8'($urandom_range(128, 255));
                default: ch = UPPER_A + 8'($urandom_range(0, 25));
            endcase
            code[CODE_W-1-8*b -: 8] = ch;
        end
        return code;
    endfunction

    // send a pooled symbol with its letters in random case
    function automatic logic [CODE_W-1:0] mixed_case(input logic [CODE_W-1:0] code);
        logic [7:0] ch;
        for (int b = 0; b < CODE_W / 8; b++) begin
            ch = code[8*b +: 8];
            if (ch >= UPPER_A && ch <= UPPER_Z && $urandom_range(0, 1) == 1) begin
                ch[5] = 1'b1;
            end
            code[8*b +: 8] = ch;
        end
        return code;
    endfunction

    // prices at or next to the held ones, or random or extreme, so equal, better and worse all come up
    function automatic logic [PRICE_W-1:0] pick_price(input logic [PRICE_W-1:0] held);
        case ($urandom_range(0, 6))
            0:       return $urandom;
            1:       return held;
            2:       return held + 1;
            3:       return held - 1;
            4:       return $urandom_range(0, 2000);
            5:       return '1;
            default: return '0;
        endcase
    endfunction

    function automatic logic [QTY_W-1:0] pick_qty();
        return ($urandom_range(0, 1) == 1) ? QTY_W'($urandom) : QTY_W'($urandom_range(0, 500));
    endfunction

    function automatic t_quote random_quote();
        t_quote q;
        int     idx;
        bit     known;
        if ($urandom_range(0, 99) < 5) begin
            q.code = {$urandom, $urandom};
        end else begin
            q.code = mixed_case(symbol_pool[$urandom_range(0, POOL_SIZE - 1)]);
        end
        known     = find_entry(fold_key(q.code), idx);
        q.bid     = pick_price(known ? book_bid[idx] : '0);
        q.ask     = pick_price(known ? book_ask[idx] : '1);
        q.bid_qty = pick_qty();
        q.ask_qty = pick_qty();
        return q;
    endfunction

    function automatic string book_text(input t_book b);
        return $sformatf("st=%0d slot=%0d bid=%h/%h ask=%h/%h",
                         b.status, b.slot, b.bid, b.bid_qty, b.ask, b.ask_qty);
    endfunction

    // append one row to the directed table
    function automatic void add_row(input t_quote q, input bit typed, input t_book want);
        t_quote_row row;
        row.q     = q;
        row.typed = typed;
        row.want  = want;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("ERROR: %s", msg);
        end
    endtask

    // offer one quote beat, with random idling ahead of it, and hold it until taken
    task automatic send_quote(input t_quote q, input bit typed, input t_book want);
        while (!quiet_window() && $urandom_range(0, 99) < 7) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_symbol_code <= q.code;
        i_bid_price   <= q.bid;
        i_ask_price   <= q.ask;
        i_bid_size    <= q.bid_qty;
        i_ask_size    <= q.ask_qty;
        typed_pending <= typed;
        typed_book    <= want;
        i_valid       <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (expected_books.size() != 0);
    endtask

    // both handshakes are watched here so a quote beat and a result beat on the
    // same edge are handled in a fixed order
    always @(posedge i_clk) begin : book_scoreboard
        t_book predicted;
        t_book seen;
        t_book want;
        if (i_rst_n && i_valid && o_ready) begin
            predicted = book_update({i_symbol_code, i_bid_price, i_ask_price,
                                     i_bid_size, i_ask_size});
            expected_books.insert(expected_books.size(),
                                  typed_pending ? typed_book : predicted);
            quotes_taken++;
        end
        if (i_rst_n && o_valid && i_ready) begin
            seen = {o_status, o_slot, o_best_bid, o_best_bid_qty, o_best_ask, o_best_ask_qty};
            if (expected_books.size() == 0) begin
                note_failure($sformatf("result %0d with nothing expected: %s",
                                       results_seen, book_text(seen)));
            end else begin
                want = expected_books.pop_front();
                if (seen.status !== want.status || seen.slot !== want.slot ||
                    seen.bid !== want.bid || seen.bid_qty !== want.bid_qty ||
                    seen.ask !== want.ask || seen.ask_qty !== want.ask_qty) begin
                    note_failure($sformatf("result %0d: expected %s, got %s", results_seen,
                                           book_text(want), book_text(seen)));
                end
            end
            results_seen++;
        end
    end

    // result sink: random back-pressure plus one long stall that fills the block
    initial begin : result_sink
        i_ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!stall_done && quotes_taken >= STALL_AT) begin
                stall_done = 1'b1;
                i_ready   <= 1'b0;
                repeat (STALL_CYCLES) @(negedge i_clk);
            end
            i_ready <= quiet_window() || ($urandom_range(0, 99) >= 7);
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("per_symbol_best_bid_ask_table: mismatch");
        $finish;
    end

    initial begin : quote_source
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_symbol_code  = '0;
        i_bid_price    = '0;
        i_ask_price    = '0;
        i_bid_size     = '0;
        i_ask_size     = '0;
        typed_pending  = 1'b0;
        typed_book     = '0;
        for (int i = 0; i < POOL_SIZE; i++) begin
            symbol_pool[i] = make_symbol();
        end

        // empty symbol, extremes of every field, equal prices
        add_row('{64'h0, 32'h0, 32'h0, 31'h0, 31'h0}, 1'b1,
                '{ST_INSERTED, 6'd0, 32'h0, 31'h0, 32'h0, 31'h0});
        add_row('{64'h0, 32'hffff_ffff, 32'h0, 31'h7fff_ffff, 31'h7fff_ffff}, 1'b1,
                '{ST_UPDATED, 6'd0, 32'hffff_ffff, 31'h7fff_ffff, 32'h0, 31'h0});
        add_row('{64'h0, 32'hffff_ffff, 32'h0, 31'h1, 31'h1}, 1'b1,
                '{ST_UNCHANGED, 6'd0, 32'hffff_ffff, 31'h7fff_ffff, 32'h0, 31'h0});
        add_row('{'1, 32'h0, 32'hffff_ffff, 31'h7fff_ffff, 31'h7fff_ffff}, 1'b1,
                '{ST_INSERTED, 6'd1, 32'h0, 31'h7fff_ffff, 32'hffff_ffff, 31'h7fff_ffff});
        add_row('{'1, 32'h0, 32'hffff_fffe, 31'd9, 31'd5}, 1'b1,
                '{ST_UPDATED, 6'd1, 32'h0, 31'h7fff_ffff, 32'hffff_fffe, 31'd5});
        // case folding: abc / ABC / aBc / AbC share one entry
        add_row('{64'h6162_6300_0000_0000, 32'd1000000, 32'd1010000, 31'd100, 31'd200},
                1'b0, '0);
        add_row('{64'h4142_4300_0000_0000, 32'd1000500, 32'd1020000, 31'd50, 31'd60},
                1'b0, '0);
        add_row('{64'h6142_6300_0000_0000, 32'd1000500, 32'd1009999, 31'd7, 31'd8},
                1'b0, '0);
        add_row('{64'h4162_4300_0000_0000, 32'd999999, 32'd1010000, 31'd1, 31'd2},
                1'b0, '0);
        // bytes just outside the letter ranges are not folded
        add_row('{64'h607b_405b_0000_0000, 32'd5, 32'd6, 31'd3, 31'd4}, 1'b0, '0);
        add_row('{64'h617a_0000_0000_0000, 32'd10, 32'd20, 31'd1, 31'd1}, 1'b0, '0);
        add_row('{64'h415a_0000_0000_0000, 32'd11, 32'd20, 31'd2, 31'd2}, 1'b0, '0);
        // bytes of 128 and above kept as they are
        add_row('{64'he1fa_80ff_0000_0000, 32'd7, 32'd9, 31'd1, 31'd1}, 1'b0, '0);
        add_row('{64'hc1da_80ff_0000_0000, 32'd7, 32'd9, 31'd1, 31'd1}, 1'b0, '0);
        // full eight-byte symbol, then worse prices on it
        add_row('{64'h6162_6364_6566_6768, 32'd300, 32'd400, 31'd9, 31'd9}, 1'b0, '0);
        add_row('{64'h4142_4344_4546_4748, 32'd299, 32'd401, 31'd8, 31'd8}, 1'b0, '0);
        // leading zero bytes form a key of their own
        add_row('{64'h4100_0000_0000_0000, 32'd1, 32'd2, 31'd1, 31'd1}, 1'b0, '0);
        add_row('{64'h0000_0000_0000_0061, 32'd1, 32'd2, 31'd1, 31'd1}, 1'b0, '0);
        add_row('{64'h0000_0000_0000_0041, 32'd1, 32'd1, 31'd6, 31'd6}, 1'b0, '0);
        // better bid and better ask in one beat
        add_row('{64'h4142_4300_0000_0000, 32'd2000000, 32'd10, 31'd77, 31'd88},
                1'b0, '0);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) begin
            send_quote(directed_rows[i].q, directed_rows[i].typed, directed_rows[i].want);
        end

        for (int n = 0; n < RANDOM_QUOTES; n++) begin
            if (n == PAUSE_AT) begin
                drain_results();
            end
            send_quote(random_quote(), 1'b0, '0);
        end

        drain_results();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("per_symbol_best_bid_ask_table: match");
        end else begin
            $display("per_symbol_best_bid_ask_table: mismatch");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/bba_pkg.sv
sv/bba_key_store.sv
sv/bba_entry_store.sv
sv/per_symbol_best_bid_ask_table.sv
verif/tb_per_symbol_best_bid_ask_table.sv
